// ===== rtl/modbus_level_reply_parser_defines.svh =====
// Assertion macros shared by the reply parser RTL.
// ASSERT_IMPL: when pre holds at a clock edge, post holds at that same edge.
// ASSERT_NEXT: when pre holds at a clock edge, post holds at the following edge.
`ifndef MODBUS_LEVEL_REPLY_PARSER_DEFINES_SVH
`define MODBUS_LEVEL_REPLY_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

// ===== rtl/mlrp_pkg.sv =====
package mlrp_pkg;

  // Frame status codes reported with each result beat.
  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StShort    = 2'd1,
    StCrcError = 2'd2,
    StHdrError = 2'd3
  } status_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CfgSlaveAddr = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgFunction  = 8'd1;

  localparam logic [7:0] SlaveAddrReset = 8'd1;
  localparam logic [7:0] FunctionReset  = 8'd3;

  // Modbus CRC-16: reflected polynomial, all-ones start value.
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Word fields sit at byte offsets 7 to 14 of the reply.
  localparam logic [7:0] WordFirstPos = 8'd7;
  localparam logic [7:0] WordLastPos  = 8'd14;
  localparam logic [7:0] ShortLimit   = 8'd3;
  localparam logic [7:0] CountMax     = 8'd255;
  localparam int unsigned NumWords    = 4;

  // One byte through the CRC, unrolled bit by bit.
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/modbus_level_reply_parser.sv =====
// Modbus RTU reply parser for a read-holding-registers answer from a level
// sensor. Reply bytes arrive one per input beat, with frame_end_i set on the
// last byte. The parser accepts one byte in every clock cycle; the frame state
// (running CRC, header check, byte count and the four data words) updates in
// the cycle the byte is taken. Each frame end produces one result beat in the
// cycle after its last byte, held in an output register until taken. The input
// stalls only while that register is full and the downstream side is not
// ready. Status is ok, too short (under four bytes), CRC mismatch or header
// mismatch, checked in that order; the data words read as zero unless ok.
// The two configuration registers may be written at any cycle (the port is
// always ready) and should be changed only between frames.
`include "modbus_level_reply_parser_defines.svh"

module modbus_level_reply_parser #(
  parameter int unsigned REGISTER_COUNT = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Byte input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          frame_end_i,
  // Result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [15:0]                   unit_code_o,
  output logic [15:0]                   decimal_places_o,
  output logic signed [15:0]            level_value_o,
  output logic signed [15:0]            zero_offset_o,
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mlrp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);

  import mlrp_pkg::*;

  localparam logic [7:0] ByteCountExp = 8'((2 * REGISTER_COUNT) % 256);

  logic [7:0]  slave_addr_q, function_q;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_hist_q;
  logic [7:0]  prev_byte_q;
  logic [7:0]  byte_cnt_q, byte_cnt_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic [15:0] words_q [NumWords];
  logic [15:0] words_d [NumWords];

  logic        out_valid_q;
  status_e     status_q, status_d;
  logic [15:0] res_q [NumWords];

  logic        in_fire, end_fire;
  logic [7:0]  word_ofs;
  logic        in_words;
  logic [1:0]  word_sel;

  // Handshakes: the output register frees the input side once taken.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign end_fire    = in_fire && frame_end_i;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SlaveAddrReset;
      function_q   <= FunctionReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgSlaveAddr) begin
        slave_addr_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgFunction) begin
        function_q <= cfg_data_i;
      end
    end
  end

  // Per-byte frame update: header check, word capture, CRC and count.
  assign word_ofs = byte_cnt_q - WordFirstPos;
  assign in_words = (byte_cnt_q >= WordFirstPos) && (byte_cnt_q <= WordLastPos);
  assign word_sel = word_ofs[2:1];

  always_comb begin
    hdr_ok_d = hdr_ok_q;
    if ((byte_cnt_q == 8'd0) && (rx_byte_i != slave_addr_q)) hdr_ok_d = 1'b0;
    if ((byte_cnt_q == 8'd1) && (rx_byte_i != function_q))   hdr_ok_d = 1'b0;
    if ((byte_cnt_q == 8'd2) && (rx_byte_i != ByteCountExp)) hdr_ok_d = 1'b0;

    for (int w = 0; w < NumWords; w++) begin
      words_d[w] = words_q[w];
    end
    if (in_words) begin
      if (!word_ofs[0]) begin
        words_d[word_sel][15:8] = rx_byte_i;
      end else begin
        words_d[word_sel][7:0] = rx_byte_i;
      end
    end

    crc_d      = crc_add_byte(crc_q, rx_byte_i);
    byte_cnt_d = (byte_cnt_q == CountMax) ? CountMax : byte_cnt_q + 8'd1;
  end

  // Status at frame end: the CRC from before the last two bytes must match them.
  always_comb begin
    if (byte_cnt_q < ShortLimit) begin
      status_d = StShort;
    end else if ((crc_hist_q[7:0] != prev_byte_q) || (crc_hist_q[15:8] != rx_byte_i)) begin
      status_d = StCrcError;
    end else if (!hdr_ok_d) begin
      status_d = StHdrError;
    end else begin
      status_d = StOk;
    end
  end

  // Frame state registers, cleared after every frame end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcInit;
      crc_hist_q  <= CrcInit;
      prev_byte_q <= 8'd0;
      byte_cnt_q  <= 8'd0;
      hdr_ok_q    <= 1'b1;
      for (int w = 0; w < NumWords; w++) begin
        words_q[w] <= 16'd0;
      end
    end else if (in_fire) begin
      if (frame_end_i) begin
        crc_q       <= CrcInit;
        crc_hist_q  <= CrcInit;
        prev_byte_q <= 8'd0;
        byte_cnt_q  <= 8'd0;
        hdr_ok_q    <= 1'b1;
        for (int w = 0; w < NumWords; w++) begin
          words_q[w] <= 16'd0;
        end
      end else begin
        crc_q       <= crc_d;
        crc_hist_q  <= crc_q;
        prev_byte_q <= rx_byte_i;
        byte_cnt_q  <= byte_cnt_d;
        hdr_ok_q    <= hdr_ok_d;
        for (int w = 0; w < NumWords; w++) begin
          words_q[w] <= words_d[w];
        end
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (end_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; words are masked to zero unless the frame is good.
  always_ff @(posedge clk_i) begin
    if (end_fire) begin
      status_q <= status_d;
      for (int w = 0; w < NumWords; w++) begin
        res_q[w] <= (status_d == StOk) ? words_d[w] : 16'd0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign unit_code_o      = res_q[0];
  assign decimal_places_o = res_q[1];
  assign level_value_o    = $signed(res_q[2]);
  assign zero_offset_o    = $signed(res_q[3]);

  // A frame end always clears the frame state and raises a result beat.
  `ASSERT_NEXT(a_frame_clear, clk_i, rst_ni, end_fire,
               (byte_cnt_q == 8'd0) && (crc_q == CrcInit) && hdr_ok_q && out_valid_o)
  // A frame ending before its fourth byte is reported as short.
  `ASSERT_NEXT(a_short_frame, clk_i, rst_ni, end_fire && (byte_cnt_q < ShortLimit),
               status_o == StShort)
  // Data words are zero on any result that is not ok.
  `ASSERT_IMPL(a_words_masked, clk_i, rst_ni, out_valid_o && (status_o != StOk),
               (unit_code_o == 16'd0) && (decimal_places_o == 16'd0) &&
               (level_value_o == 16'sd0) && (zero_offset_o == 16'sd0))

endmodule
